### sv/assert_macros.svh
// shared assertion macros, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// whenever ante holds in a cycle, cons holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// whenever ante holds in a cycle, cons holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/blfs_pkg.sv
`default_nettype none

package blfs_pkg;

    // fixed field widths
    localparam int WordW   = 64;
    localparam int OpW     = 3;
    localparam int PosW    = 6;
    localparam int CountW  = 7;
    localparam int StatusW = 2;
    localparam int InDataW  = 72;
    localparam int OutDataW = 72;

    // build defaults
    localparam int DefDepth = 64;
    localparam logic [CountW-1:0] CapacityReset = 7'd64;

    // operation codes
    localparam logic [OpW-1:0] OP_PUSH = 3'd0;
    localparam logic [OpW-1:0] OP_POP  = 3'd1;
    localparam logic [OpW-1:0] OP_TOP  = 3'd2;
    localparam logic [OpW-1:0] OP_GET  = 3'd3;
    localparam logic [OpW-1:0] OP_PICK = 3'd4;

    // status codes
    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
    localparam logic [StatusW-1:0] ST_RANGE = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_valid;
    } stat_t;

endpackage

`default_nettype wire

### sv/bounded_lifo_stack_with_pick.sv
// bounded lifo stack of 64-bit words with get and pick access
// requests enter on s_*: s_tuser holds the operation (push, pop, top, get
// from bottom, pick from top), s_tdata holds the push word and the position
// results leave on m_*: one result per request, in request order, with the
// word read, the depth after the operation, an empty flag and a status in
// m_tuser (ok, empty, full, index out of range); a failed request changes
// nothing and returns a zero word
// cfg_valid/cfg_data write the capacity limit; cfg_ready stays high, so
// writes belong to cycles with no request in flight
// a request is captured on accept, then the store is accessed with
// registered read data, then the result is loaded into the output register
// once that register is free; a new request is taken only after the
// controller's accept, execute and finish steps, with one request in flight
// the next request is accepted while a result waits in the output register;
// when the receiver stalls, the finished result after that waits inside
// reset clears the stack to empty, sets capacity to 64 and drops any result;
// the store needs no clearing pass
`default_nettype none

module bounded_lifo_stack_with_pick #(
    parameter int DEPTH = blfs_pkg::DefDepth
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [63:0] push_value, [69:64] position, [71:70] zero
    input  wire logic [blfs_pkg::InDataW-1:0]    s_tdata,
    // [2:0] op
    input  wire logic [blfs_pkg::OpW-1:0]        s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [63:0] read_value, [70:64] depth_now, [71] is_empty
    output logic [blfs_pkg::OutDataW-1:0]        m_tdata,
    // [1:0] status
    output logic [blfs_pkg::StatusW-1:0]         m_tuser,
    // capacity write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [blfs_pkg::CountW-1:0]     cfg_data
);

    blfs_pkg::cmd_t  cmd;
    blfs_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencing
    blfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack store, counters and output register
    blfs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (s_tuser),
        .in_value    (s_tdata[blfs_pkg::WordW-1:0]),
        .in_position (s_tdata[blfs_pkg::WordW +: blfs_pkg::PosW]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .m_tready    (m_tready),
        .out_data    (m_tdata),
        .out_status  (m_tuser),
        .out_valid   (m_tvalid)
    );

endmodule

`default_nettype wire

### sv/blfs_ctrl.sv
`default_nettype none

module blfs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          m_tready,
    input  wire blfs_pkg::stat_t stat,
    output blfs_pkg::cmd_t     cmd
);

    `include "assert_macros.svh"

    blfs_pkg::state_t state_reg;
    blfs_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            blfs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = blfs_pkg::ST_EXEC;
                end
            end
            blfs_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = blfs_pkg::ST_FINISH;
            end
            blfs_pkg::ST_FINISH:
            begin
                // move the result once the output register is free
                if (!stat.out_valid || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = blfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blfs_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_then_exec, s_tvalid && s_tready, cmd.exec, "accepted request not executed")
    `ASSERT_SAME(a_no_accept_busy, cmd.exec || cmd.load_out, !s_tready, "request accepted while busy")

endmodule

`default_nettype wire

### sv/blfs_dp.sv
`default_nettype none

module blfs_dp #(
    parameter int DEPTH = blfs_pkg::DefDepth
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire blfs_pkg::cmd_t                cmd,
    output blfs_pkg::stat_t                    stat,
    input  wire logic [blfs_pkg::OpW-1:0]      in_op,
    input  wire logic [blfs_pkg::WordW-1:0]    in_value,
    input  wire logic [blfs_pkg::PosW-1:0]     in_position,
    input  wire logic                          cfg_valid,
    input  wire logic [blfs_pkg::CountW-1:0]   cfg_data,
    input  wire logic                          m_tready,
    output logic [blfs_pkg::OutDataW-1:0]      out_data,
    output logic [blfs_pkg::StatusW-1:0]       out_status,
    output logic                               out_valid
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CountMax = (1 << blfs_pkg::CountW) - 1;
    // hardest bound on the count: built depth, or what the count can hold
    localparam int LimCap = (DEPTH > CountMax) ? CountMax : DEPTH;
    localparam logic [blfs_pkg::CountW-1:0] LimCapC = blfs_pkg::CountW'(LimCap);

    logic [blfs_pkg::OpW-1:0]     op_reg;
    logic [blfs_pkg::WordW-1:0]   value_reg;
    logic [blfs_pkg::PosW-1:0]    pos_reg;
    logic [blfs_pkg::CountW-1:0]  capacity_reg;
    logic [blfs_pkg::CountW-1:0]  fill_count_reg;
    logic [blfs_pkg::CountW-1:0]  fill_count_next;
    logic [blfs_pkg::StatusW-1:0] status_reg;
    logic [blfs_pkg::StatusW-1:0] status_next;
    logic                         use_rd_reg;
    logic                         use_rd_next;
    logic [blfs_pkg::WordW-1:0]   rdata_reg;
    logic [blfs_pkg::OutDataW-1:0] out_data_reg;
    logic [blfs_pkg::StatusW-1:0] out_status_reg;
    logic                         out_valid_reg;
    logic                         wr_en;
    logic [blfs_pkg::CountW-1:0]  rd_idx;
    logic [blfs_pkg::CountW-1:0]  limit;
    logic [blfs_pkg::CountW-1:0]  pos_ext;
    logic [blfs_pkg::CountW-1:0]  count_inc;
    logic [blfs_pkg::WordW-1:0]   entry_mem [DEPTH];

    assign pos_ext   = {1'b0, pos_reg};
    assign limit     = (capacity_reg < LimCapC) ? capacity_reg : LimCapC;
    assign count_inc = fill_count_reg + 7'd1;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= blfs_pkg::CapacityReset;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // operation decode: status, count update, store access
    always_comb
    begin
        fill_count_next = fill_count_reg;
        status_next     = blfs_pkg::ST_OK;
        use_rd_next     = 1'b0;
        wr_en           = 1'b0;
        rd_idx          = fill_count_reg - 7'd1;
        case (op_reg)
            blfs_pkg::OP_PUSH:
            begin
                if (fill_count_reg >= limit)
                begin
                    status_next = blfs_pkg::ST_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    fill_count_next = fill_count_reg + 7'd1;
                end
            end
            blfs_pkg::OP_POP:
            begin
                if (fill_count_reg == '0)
                begin
                    status_next = blfs_pkg::ST_EMPTY;
                end
                else
                begin
                    use_rd_next     = 1'b1;
                    fill_count_next = fill_count_reg - 7'd1;
                end
            end
            blfs_pkg::OP_TOP:
            begin
                if (fill_count_reg == '0)
                begin
                    status_next = blfs_pkg::ST_EMPTY;
                end
                else
                begin
                    use_rd_next = 1'b1;
                end
            end
            blfs_pkg::OP_GET:
            begin
                rd_idx = pos_ext;
                if (pos_ext >= fill_count_reg)
                begin
                    status_next = blfs_pkg::ST_RANGE;
                end
                else
                begin
                    use_rd_next = 1'b1;
                end
            end
            blfs_pkg::OP_PICK:
            begin
                rd_idx = fill_count_reg - 7'd1 - pos_ext;
                if (pos_ext >= fill_count_reg)
                begin
                    status_next = blfs_pkg::ST_RANGE;
                end
                else
                begin
                    use_rd_next = 1'b1;
                end
            end
            default:
            begin
                status_next = blfs_pkg::ST_OK;
            end
        endcase
    end

    // entry store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            entry_mem[AW'(fill_count_reg)] <= value_reg;
        end
        if (cmd.exec)
        begin
            rdata_reg <= entry_mem[AW'(rd_idx)];
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // execution result
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            use_rd_reg <= use_rd_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= {fill_count_reg == '0, fill_count_reg,
                               use_rd_reg ? rdata_reg : {blfs_pkg::WordW{1'b0}}};
            out_status_reg <= status_reg;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_data       = out_data_reg;
    assign out_status     = out_status_reg;
    assign out_valid      = out_valid_reg;
    assign stat.out_valid = out_valid_reg;

    `ASSERT_SAME(a_count_bound, 1'b1, fill_count_reg <= LimCapC, "fill count beyond built depth")
    `ASSERT_NEXT(a_push_grows, cmd.exec && wr_en, fill_count_reg == $past(count_inc), "push lost")
    `ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid_reg || m_tready, "unsent result overwritten")

endmodule

`default_nettype wire
